// ===== sv/lsc_pkg.sv =====
// Shared types, constants and op codes of the I/O latency statistics collector.
// No dependencies; every other file imports this package.
package lsc_pkg;

    localparam int LAT_W             = 64;
    localparam int CNT_W             = 32;
    localparam int SIZE_W            = 32;
    localparam int DEF_NUM_BUCKETS   = 12;
    localparam int DEF_MIN_SIZE_LOG2 = 11;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] M_TOTAL   = 2'd0;
    localparam logic [1:0] M_BACKEND = 2'd1;
    localparam logic [1:0] M_NET     = 2'd2;
    localparam logic [1:0] M_QOS     = 2'd3;

    typedef struct packed {
        logic [LAT_W-1:0] min_lat;
        logic [LAT_W-1:0] max_lat;
        logic [LAT_W-1:0] sum_lat;
    } t_stat;

endpackage

// ===== sv/lsc_alu.sv =====
// Shared 64-bit add/subtract unit with carry out; a clear carry on subtract
// flags a < b. Depends on lsc_pkg.
module lsc_alu (
    input  logic [lsc_pkg::LAT_W-1:0] i_a,
    input  logic [lsc_pkg::LAT_W-1:0] i_b,
    input  logic                      i_sub,
    output logic [lsc_pkg::LAT_W-1:0] o_res,
    output logic                      o_carry
);
    import lsc_pkg::*;

    logic [LAT_W-1:0] w_b;

    assign w_b = i_sub ? ~i_b : i_b;
    assign {o_carry, o_res} = {1'b0, i_a} + {1'b0, w_b} + (LAT_W + 1)'(i_sub);

endmodule

// ===== sv/lsc_stat_mem.sv =====
// Per-metric min/max/sum memory with one write and one registered read port.
// Entry valid bits double as the min-set flags; depends on lsc_pkg.
module lsc_stat_mem #(
    parameter  int DEPTH = 96,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  lsc_pkg::t_stat   i_wdata,
    output lsc_pkg::t_stat   o_rdata,
    output logic             o_rvalid
);
    import lsc_pkg::*;

    t_stat            r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_stat            r_rd;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rd <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_addr];
        end
    end

    // never-written entries read as zero
    assign o_rdata  = r_rd_valid ? r_rd : '0;
    assign o_rvalid = r_rd_valid;

endmodule

// ===== sv/io_latency_stats_collector.sv =====
// I/O latency statistics collector: size-bucketed min/max/sum of four latencies.
// Record: busy after acceptance (bucket, count, then latency, min, max and sum
// steps per metric on the shared 64-bit adder), only bucket if the record is skipped.
// Query: busy through the read and output states, result registered, longer while
// the result side stalls; clear and unused ops: next item accepted the next cycle.
// Reset (synchronous, active low) and the clear op zero all statistics at once.
module io_latency_stats_collector #(
    parameter int NUM_BUCKETS   = lsc_pkg::DEF_NUM_BUCKETS,
    parameter int MIN_SIZE_LOG2 = lsc_pkg::DEF_MIN_SIZE_LOG2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_op,
    input  logic                        i_is_write,
    input  logic                        i_ok_status,
    input  logic [lsc_pkg::SIZE_W-1:0]  i_io_size,
    input  logic [lsc_pkg::LAT_W-1:0]   i_t_cmd_recv,
    input  logic [lsc_pkg::LAT_W-1:0]   i_t_resp_sent,
    input  logic [lsc_pkg::LAT_W-1:0]   i_t_backend_start,
    input  logic [lsc_pkg::LAT_W-1:0]   i_t_backend_end,
    input  logic [lsc_pkg::LAT_W-1:0]   i_t_net_start,
    input  logic [lsc_pkg::LAT_W-1:0]   i_write_net_lat,
    input  logic [lsc_pkg::LAT_W-1:0]   i_qos_lat,
    input  logic [5:0]                  i_query_slot,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [lsc_pkg::CNT_W-1:0]   o_group_count,
    output logic [lsc_pkg::CNT_W-1:0]   o_total_ios,
    output logic                        o_min_valid,
    output logic [lsc_pkg::LAT_W-1:0]   o_min_latency,
    output logic [lsc_pkg::LAT_W-1:0]   o_max_latency,
    output logic [lsc_pkg::LAT_W-1:0]   o_latency_sum
);
    import lsc_pkg::*;

    localparam int NG     = NUM_BUCKETS * 2;
    localparam int MDEPTH = NG * 4;
    localparam int IW     = $clog2(MDEPTH);
    localparam int GW     = IW - 2;
    localparam int BW     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam logic [SIZE_W-1:0] FLOOR_SIZE = SIZE_W'(1) << MIN_SIZE_LOG2;
    localparam logic [4:0] MIN_LG   = 5'(MIN_SIZE_LOG2);
    localparam logic [4:0] LAST_BKT = 5'(NUM_BUCKETS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_BKT, S_CNT, S_LAT, S_MIN, S_MAX, S_SUM, S_QRD, S_QOUT
    } t_state;

    t_state            r_state;
    logic              r_wr;
    logic              r_ok;
    logic [SIZE_W-1:0] r_size;
    logic [LAT_W-1:0]  r_recv, r_resp, r_bs, r_be, r_ns, r_wnet, r_qos;
    logic [GW-1:0]     r_grp;
    logic [1:0]        r_metric;
    logic              r_oor;
    logic [LAT_W-1:0]  r_lat, r_new_min, r_new_max;
    logic [CNT_W-1:0]  r_grp_cnt [NG];
    logic [CNT_W-1:0]  r_all_cnt;
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_out_grp_cnt, r_out_total;
    logic              r_out_min_valid;
    logic [LAT_W-1:0]  r_out_min, r_out_max, r_out_sum;

    logic              w_accept;
    logic              w_clr;
    logic [3:0]        w_qbkt;
    logic              w_q_oor;
    logic [SIZE_W-1:0] w_size_c;
    logic [4:0]        w_lg, w_bkt;
    logic              w_skip;
    logic [LAT_W-1:0]  w_a, w_b;
    logic              w_sub;
    logic [LAT_W-1:0]  w_res;
    logic              w_carry;
    logic              w_we;
    logic [IW-1:0]     w_addr;
    t_stat             w_wdata, w_rdata;
    logic              w_rvalid;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_clr    = w_accept && (i_op == OP_CLEAR);

    assign w_qbkt  = i_query_slot[5:2];
    assign w_q_oor = int'(w_qbkt) >= NUM_BUCKETS;

    // size bucket: clamp up to the floor size, floor log2, offset and clamp
    always_comb begin
        w_size_c = (r_size < FLOOR_SIZE) ? FLOOR_SIZE : r_size;
        w_lg = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (w_size_c[i]) begin
                w_lg = 5'(i);
            end
        end
        w_bkt = (w_lg >= MIN_LG) ? (w_lg - MIN_LG) : '0;
        if (w_bkt > LAST_BKT) begin
            w_bkt = LAST_BKT;
        end
    end

    assign w_skip = (r_recv == '0) || !r_ok || (!r_wr && (r_ns == '0));

    // shared unit operand select
    always_comb begin
        w_a   = r_lat;
        w_b   = w_rdata.min_lat;
        w_sub = 1'b1;
        case (r_state)
            S_LAT: begin
                case (r_metric)
                    M_TOTAL: begin
                        w_a = r_resp;
                        w_b = r_recv;
                    end
                    M_BACKEND: begin
                        w_a = r_wr ? r_resp : r_be;
                        w_b = r_bs;
                    end
                    M_NET: begin
                        w_a = r_wr ? r_wnet : r_resp;
                        w_b = r_wr ? '0 : r_ns;
                    end
                    default: begin
                        w_a = r_qos;
                        w_b = '0;
                    end
                endcase
            end
            S_MAX: begin
                w_a = w_rdata.max_lat;
                w_b = r_lat;
            end
            S_SUM: begin
                w_a   = w_rdata.sum_lat;
                w_b   = r_lat;
                w_sub = 1'b0;
            end
            default: begin
                w_a = r_lat;
                w_b = w_rdata.min_lat;
            end
        endcase
    end

    lsc_alu u_alu (
        .i_a     (w_a),
        .i_b     (w_b),
        .i_sub   (w_sub),
        .o_res   (w_res),
        .o_carry (w_carry)
    );

    assign w_addr          = IW'({r_grp, r_metric});
    assign w_we            = (r_state == S_SUM);
    assign w_wdata.min_lat = r_new_min;
    assign w_wdata.max_lat = r_new_max;
    assign w_wdata.sum_lat = w_res;

    lsc_stat_mem #(
        .DEPTH (MDEPTH)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (w_clr),
        .i_we     (w_we),
        .i_addr   (w_addr),
        .i_wdata  (w_wdata),
        .o_rdata  (w_rdata),
        .o_rvalid (w_rvalid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_all_cnt   <= '0;
            for (int g = 0; g < NG; g++) begin
                r_grp_cnt[g] <= '0;
            end
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_QOUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_wr   <= i_is_write;
                        r_ok   <= i_ok_status;
                        r_size <= i_io_size;
                        r_recv <= i_t_cmd_recv;
                        r_resp <= i_t_resp_sent;
                        r_bs   <= i_t_backend_start;
                        r_be   <= i_t_backend_end;
                        r_ns   <= i_t_net_start;
                        r_wnet <= i_write_net_lat;
                        r_qos  <= i_qos_lat;
                        case (i_op)
                            OP_RECORD: begin
                                r_state <= S_BKT;
                            end
                            OP_QUERY: begin
                                r_oor    <= w_q_oor;
                                r_grp    <= w_q_oor ? '0 : GW'({BW'(w_qbkt), i_is_write});
                                r_metric <= i_query_slot[1:0];
                                r_state  <= S_QRD;
                            end
                            OP_CLEAR: begin
                                r_all_cnt <= '0;
                                for (int g = 0; g < NG; g++) begin
                                    r_grp_cnt[g] <= '0;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_BKT: begin
                    r_grp    <= GW'({BW'(w_bkt), r_wr});
                    r_metric <= M_TOTAL;
                    r_state  <= w_skip ? S_IDLE : S_CNT;
                end
                S_CNT: begin
                    // saturate both counters
                    if (r_all_cnt != CNT_MAX) begin
                        r_all_cnt <= r_all_cnt + 1'b1;
                    end
                    if (r_grp_cnt[r_grp] != CNT_MAX) begin
                        r_grp_cnt[r_grp] <= r_grp_cnt[r_grp] + 1'b1;
                    end
                    r_state <= S_LAT;
                end
                S_LAT: begin
                    r_lat   <= w_res;
                    r_state <= S_MIN;
                end
                S_MIN: begin
                    // no carry on lat - min: lat is smaller
                    r_new_min <= (!w_rvalid || !w_carry) ? r_lat : w_rdata.min_lat;
                    r_state   <= S_MAX;
                end
                S_MAX: begin
                    r_new_max <= !w_carry ? r_lat : w_rdata.max_lat;
                    r_state   <= S_SUM;
                end
                S_SUM: begin
                    if (r_metric == M_QOS) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_metric <= r_metric + 1'b1;
                        r_state  <= S_LAT;
                    end
                end
                S_QRD: begin
                    r_state <= S_QOUT;
                end
                S_QOUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid     <= 1'b1;
                        r_out_total     <= r_all_cnt;
                        r_out_grp_cnt   <= r_oor ? '0 : r_grp_cnt[r_grp];
                        r_out_min_valid <= !r_oor && w_rvalid;
                        r_out_min       <= r_oor ? '0 : w_rdata.min_lat;
                        r_out_max       <= r_oor ? '0 : w_rdata.max_lat;
                        r_out_sum       <= r_oor ? '0 : w_rdata.sum_lat;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_group_count = r_out_grp_cnt;
    assign o_total_ios   = r_out_total;
    assign o_min_valid   = r_out_min_valid;
    assign o_min_latency = r_out_min;
    assign o_max_latency = r_out_max;
    assign o_latency_sum = r_out_sum;

endmodule
